// File: rtl/tqpr_pkg.sv
package tqpr_pkg;
   localparam int MaxPages = 256;
   localparam int PageBits = 32;
   localparam int CapBits  = 9;

   typedef enum logic [1:0] {
      OUT_COLD  = 2'd0,
      OUT_PROMO = 2'd1,
      OUT_MAIN  = 2'd2,
      OUT_GHOST = 2'd3
   } outcome_type;

   localparam logic [1:0] EVICT_PROB = 2'd0;
   localparam logic [1:0] EVICT_MAIN = 2'd1;
endpackage

// File: rtl/tqpr_if.sv
interface tqpr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] page_no;
   modport source (output valid, func, page_no, input ready);
   modport sink   (input valid, func, page_no, output ready);
endinterface

interface tqpr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [1:0]  outcome;
   logic [31:0] page;
   logic [7:0]  frame;
   logic        dirty;
   logic        last;
   modport source (output valid, kind, outcome, page, frame, dirty, last, input ready);
   modport sink   (input valid, kind, outcome, page, frame, dirty, last, output ready);
endinterface

interface tqpr_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/tqpr_cell.sv
// One frame or ghost slot: page tag, queue membership and rank. Commands are
// broadcast; the slot updates its own rank and reports match/tail hits.
module tqpr_cell #(
   parameter int PageBits = tqpr_pkg::PageBits,
   parameter int RankBits = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [PageBits-1:0] key,
   input  logic [RankBits:0]   tail_rank,
   input  logic                tail_q,
   input  logic                op_remove,
   input  logic                op_push,
   input  logic                op_write,
   input  logic                sel,
   input  logic                op_q,
   input  logic [RankBits:0]   op_rank,
   input  logic                set_dirty,
   input  logic                clr_dirty,
   output logic                match,
   output logic                is_tail,
   output logic                valid,
   output logic                in_main,
   output logic                dirty,
   output logic [RankBits:0]   rank,
   output logic [PageBits-1:0] page
);
   import tqpr_pkg::*;
   logic                valid_ff, valid_in, main_ff, main_in, dirty_ff, dirty_in;
   logic [RankBits:0]   rank_ff, rank_in;
   logic [PageBits-1:0] page_ff;

   assign match   = valid_ff && page_ff == key;
   assign is_tail = valid_ff && main_ff == tail_q && rank_ff == tail_rank;
   assign valid = valid_ff;
   assign in_main = main_ff;
   assign dirty = dirty_ff;
   assign rank = rank_ff;
   assign page = page_ff;

   always_comb begin
      valid_in = valid_ff;
      main_in  = main_ff;
      rank_in  = rank_ff;
      dirty_in = dirty_ff;
      if (op_remove) begin
         if (sel) valid_in = 1'b0;
         else if (valid_ff && main_ff == op_q && rank_ff > op_rank) rank_in = rank_ff - 1'b1;
      end
      if (op_push) begin
         if (sel) begin
            valid_in = 1'b1;
            main_in  = op_q;
            rank_in  = '0;
         end else if (valid_ff && main_ff == op_q) begin
            rank_in = rank_ff + 1'b1;
         end
      end
      if (sel && clr_dirty) dirty_in = 1'b0;
      if (sel && set_dirty) dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         main_ff  <= 1'b0;
         rank_ff  <= '0;
         dirty_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         main_ff  <= main_in;
         rank_ff  <= rank_in;
         dirty_ff <= dirty_in;
      end
      if (sel && op_write) page_ff <= key;
   end
endmodule

// File: rtl/two_queue_page_replacement.sv
// Two-queue page replacement controller. Each request word is one page access;
// the block answers with up to two eviction words (kind 0) and then one access
// word (kind 1, last 1). Frames and ghosts are rows of slot cells, each holding
// its tag, queue flag and rank; matches and tail searches are associative and
// rank shifts are broadcast to all cells. A sequencer takes one access at a
// time: a lookup, then the queue steps (remove, evict, ghost
// trim, push), each eviction or result word waiting in the output register.
// The request side stays busy until the access word is loaded into the output
// register. An eviction from the main queue goes back to the room check; one
// from A1in first passes the ghost step, which moves a ghost already held to
// the head or trims the ghost tail, and a stalled receiver holds the output
// word and the sequencer with it. The lowest free frame and ghost slot come
// from priority encoders over the valid bits.
module two_queue_page_replacement #(
   parameter int MaxPages = tqpr_pkg::MaxPages,
   parameter int PageBits = tqpr_pkg::PageBits
) (
   input logic clock,
   input logic reset,
   tqpr_req_if.sink   req,
   tqpr_rsp_if.source rsp,
   tqpr_csr_if.sink   csr
);
   import tqpr_pkg::*;
   localparam int Ghosts = MaxPages / 2;
   localparam int FB = $clog2(MaxPages);
   localparam int GB = $clog2(Ghosts);
   localparam int CB = FB + 1;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_LOOK  = 8'b00000010,
      S_DET   = 8'b00000100,
      S_ROOM  = 8'b00001000,
      S_EVICT = 8'b00010000,
      S_GHOST = 8'b00100000,
      S_PUSH  = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   typedef struct packed {
      logic remove, push, write, q, set_dirty, clr_dirty;
   } cmd_type;

   state_type state_ff, state_in;
   logic [CapBits-1:0] capacity_ff;
   logic [CB-1:0] pcnt_ff, mcnt_ff, gcnt_ff;
   logic wr_ff; logic [PageBits-1:0] key_ff;
   logic [1:0] outc_ff; logic [FB-1:0] f_ff; logic [1:0] evn_ff;
   logic evq_ff; logic [PageBits-1:0] gkey_ff; logic [1:0] roomm_ff;

   logic ov_ff; logic okind_ff; logic [1:0] oout_ff; logic [31:0] opage_ff;
   logic [7:0] oframe_ff; logic odirty_ff;

   // effective limits
   logic [CB-1:0] cap, kin, amcap, kout;
   always_comb begin
      cap = (capacity_ff < 9'd4) ? CB'(4) :
            ({1'b0, capacity_ff} > 10'(MaxPages)) ? CB'(MaxPages) : CB'(capacity_ff);
      kin = cap >> 2; amcap = cap - kin; kout = cap >> 1;
   end

   // frame row
   cmd_type fc; logic [CB-1:0] f_rank, f_tail; logic f_tq;
   logic [PageBits-1:0] fkey;
   logic [MaxPages-1:0] fmatch, ftail, fvalid, fmain, fdirty, fsel;
   logic [PageBits-1:0] fpage [MaxPages];
   logic [CB-1:0] frank [MaxPages];
   genvar gi;
   for (gi = 0; gi < MaxPages; gi++) begin : g_frame
      tqpr_cell #(.PageBits(PageBits), .RankBits(FB)) u_cell (
         .clock, .reset, .key(fkey), .tail_rank(f_tail), .tail_q(f_tq),
         .op_remove(fc.remove), .op_push(fc.push), .op_write(fc.write), .sel(fsel[gi]),
         .op_q(fc.q), .op_rank(f_rank), .set_dirty(fc.set_dirty), .clr_dirty(fc.clr_dirty),
         .match(fmatch[gi]), .is_tail(ftail[gi]), .valid(fvalid[gi]), .in_main(fmain[gi]),
         .dirty(fdirty[gi]), .rank(frank[gi]), .page(fpage[gi]));
   end

   // ghost row
   cmd_type gc; logic [GB:0] g_rank, g_tail; logic [PageBits-1:0] gkey;
   logic [Ghosts-1:0] gmatch, gtail, gvalid, gsel, gmn, gdn;
   logic [PageBits-1:0] gpage [Ghosts];
   logic [GB:0] grank [Ghosts];
   for (gi = 0; gi < Ghosts; gi++) begin : g_ghost
      tqpr_cell #(.PageBits(PageBits), .RankBits(GB)) u_cell (
         .clock, .reset, .key(gkey), .tail_rank(g_tail), .tail_q(1'b0),
         .op_remove(gc.remove), .op_push(gc.push), .op_write(gc.write), .sel(gsel[gi]),
         .op_q(1'b0), .op_rank(g_rank), .set_dirty(1'b0), .clr_dirty(1'b0),
         .match(gmatch[gi]), .is_tail(gtail[gi]), .valid(gvalid[gi]), .in_main(gmn[gi]),
         .dirty(gdn[gi]), .rank(grank[gi]), .page(gpage[gi]));
   end

   // encoders: last frame match wins, lowest free slot is taken
   logic fm_any, ft_any, gm_any, gt_any, ff_any, gf_any;
   logic [FB-1:0] fm_idx, ft_idx, ff_idx; logic [GB-1:0] gm_idx, gt_idx, gf_idx;
   always_comb begin
      fm_any = 1'b0; fm_idx = '0; ft_any = 1'b0; ft_idx = '0; ff_any = 1'b0; ff_idx = '0;
      for (int i = 0; i < MaxPages; i++) begin
         if (fmatch[i]) begin fm_any = 1'b1; fm_idx = FB'(i); end
         if (ftail[i]) begin ft_any = 1'b1; ft_idx = FB'(i); end
      end
      for (int i = MaxPages - 1; i >= 0; i--)
         if (!fvalid[i]) begin ff_any = 1'b1; ff_idx = FB'(i); end
      gm_any = 1'b0; gm_idx = '0; gt_any = 1'b0; gt_idx = '0; gf_any = 1'b0; gf_idx = '0;
      for (int i = Ghosts - 1; i >= 0; i--) begin
         if (gmatch[i]) begin gm_any = 1'b1; gm_idx = GB'(i); end
         if (!gvalid[i]) begin gf_any = 1'b1; gf_idx = GB'(i); end
      end
      for (int i = 0; i < Ghosts; i++)
         if (gtail[i]) begin gt_any = 1'b1; gt_idx = GB'(i); end
   end

   // control
   logic out_free;
   assign out_free = !ov_ff || rsp.ready;
   assign req.ready = state_ff == S_IDLE;
   assign csr.ready = 1'b1;

   logic [CB-1:0] qcnt_tail;
   logic emit_ev, emit_res, room_need, room_q;
   logic ghost_reentry_ff;

   always_comb begin
      state_in = state_ff;
      fc = '0; gc = '0; fsel = '0; gsel = '0;
      fkey = key_ff; gkey = key_ff;
      f_rank = '0; f_tail = '0; f_tq = 1'b0; g_rank = '0;
      g_tail = (GB+1)'(gcnt_ff - 1'b1);
      emit_ev = 1'b0; emit_res = 1'b0; room_need = 1'b0; room_q = 1'b0;
      qcnt_tail = '0;
      // room decision: roomm_ff[0] 1 = for main, 0 = for probation;
      // roomm_ff[1] marks the first loop as finished
      if (evn_ff != 2'd2) begin
         if (roomm_ff[0]) begin
            if (!roomm_ff[1] && mcnt_ff >= amcap && mcnt_ff != 0) begin
               room_need = 1'b1; room_q = 1'b1;
            end else if (pcnt_ff + mcnt_ff >= cap) begin
               room_need = 1'b1; room_q = pcnt_ff == 0;
            end
         end else if (!roomm_ff[1]) begin
            if (pcnt_ff >= kin) begin
               room_need = 1'b1; room_q = 1'b0;
            end else if (pcnt_ff + mcnt_ff >= cap) begin
               room_need = 1'b1; room_q = mcnt_ff == 0;
            end
         end
      end
      case (state_ff)
         S_EVICT: begin
            qcnt_tail = evq_ff ? mcnt_ff : pcnt_ff;
            f_tail = qcnt_tail - 1'b1; f_tq = evq_ff;
         end
         default: ;
      endcase
      case (state_ff)
         S_IDLE: if (req.valid) state_in = S_LOOK;
         S_LOOK: state_in = S_DET;
         S_DET: state_in = S_ROOM;
         S_ROOM: begin
            if (room_need) state_in = S_EVICT;
            else state_in = S_PUSH;
         end
         S_EVICT: begin
            if (!ft_any) state_in = S_PUSH;
            else if (out_free) begin
               emit_ev = 1'b1;
               fsel[ft_idx] = 1'b1;
               fc.remove = 1'b1; fc.q = evq_ff; f_rank = frank[ft_idx];
               fc.clr_dirty = 1'b1;
               state_in = evq_ff ? S_ROOM : S_GHOST;
            end
         end
         S_GHOST: begin
            gkey = gkey_ff;
            if (gm_any) begin
               // move existing ghost to head: remove then push in two steps
               gsel[gm_idx] = 1'b1; gc.remove = 1'b1; g_rank = grank[gm_idx];
               state_in = S_GHOST;
            end else if (!ghost_reentry_ff && gcnt_ff >= kout && gcnt_ff != 0 && gt_any) begin
               gsel[gt_idx] = 1'b1; gc.remove = 1'b1; g_rank = grank[gt_idx];
            end else begin
               gsel[gf_idx] = gf_any; gc.push = gf_any; gc.write = gf_any;
               state_in = S_ROOM;
            end
         end
         S_PUSH: begin
            if (outc_ff == OUT_COLD || outc_ff == OUT_GHOST) begin
               fsel[ff_idx] = 1'b1; fc.write = 1'b1; fc.clr_dirty = 1'b1;
            end else fsel[f_ff] = 1'b1;
            fc.push = 1'b1; fc.q = outc_ff != OUT_COLD; fc.set_dirty = wr_ff;
            state_in = S_DONE;
         end
         S_DONE: if (out_free) begin emit_res = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_DET) begin
         if (fm_any) begin
            fsel[fm_idx] = 1'b1; fc.remove = 1'b1; fc.q = fmain[fm_idx];
            f_rank = frank[fm_idx];
            if (fmain[fm_idx]) state_in = S_PUSH;
         end else if (gm_any) begin
            gsel[gm_idx] = 1'b1; gc.remove = 1'b1; g_rank = grank[gm_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; capacity_ff <= 9'd256;
         pcnt_ff <= '0; mcnt_ff <= '0; gcnt_ff <= '0; ov_ff <= 1'b0;
         evn_ff <= '0; ghost_reentry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) capacity_ff <= csr.data;
         if (emit_ev || emit_res) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
         if (fc.remove) begin
            if (fc.q) begin if (mcnt_ff != 0) mcnt_ff <= mcnt_ff - 1'b1; end
            else if (pcnt_ff != 0) pcnt_ff <= pcnt_ff - 1'b1;
         end
         if (fc.push) begin
            if (fc.q) mcnt_ff <= mcnt_ff + 1'b1; else pcnt_ff <= pcnt_ff + 1'b1;
         end
         if (gc.remove && !gc.push) begin if (gcnt_ff != 0) gcnt_ff <= gcnt_ff - 1'b1; end
         if (gc.push) gcnt_ff <= gcnt_ff + 1'b1;
         // a held ghost moved to the head skips the trim
         if (state_ff == S_GHOST) ghost_reentry_ff <= gm_any;
         if (state_ff == S_IDLE && req.valid) begin evn_ff <= '0; roomm_ff <= 2'b00; end
         if (state_ff == S_DET) begin
            roomm_ff <= {1'b0, fm_any || gm_any};
            if (fm_any) f_ff <= fm_idx;
         end
         if (state_ff == S_ROOM && room_need) evq_ff <= room_q;
         if (emit_ev) begin
            okind_ff <= 1'b0;
            oout_ff <= evq_ff ? EVICT_MAIN : EVICT_PROB;
            opage_ff <= 32'(fpage[ft_idx]); oframe_ff <= 8'(ft_idx);
            odirty_ff <= fdirty[ft_idx]; gkey_ff <= fpage[ft_idx];
            evn_ff <= evn_ff + 1'b1;
            // main: first loop done once under its limit; probation: a full
            // A1in gets one eviction and nothing more
            if (roomm_ff[0] ? (mcnt_ff < amcap + 1'b1) : (!evq_ff && pcnt_ff >= kin))
               roomm_ff[1] <= 1'b1;
         end
         if (state_ff == S_PUSH && (outc_ff == OUT_COLD || outc_ff == OUT_GHOST))
            f_ff <= ff_idx;
         if (emit_res) begin
            okind_ff <= 1'b1; oout_ff <= outc_ff; opage_ff <= 32'(key_ff);
            oframe_ff <= 8'(f_ff); odirty_ff <= fdirty[f_ff];
         end
      end
      if (state_ff == S_IDLE && req.valid) begin
         wr_ff <= req.func; key_ff <= PageBits'(req.page_no);
      end
      if (state_ff == S_DET)
         outc_ff <= fm_any ? (fmain[fm_idx] ? OUT_MAIN : OUT_PROMO) :
                    gm_any ? OUT_GHOST : OUT_COLD;
   end

   assign rsp.valid = ov_ff; assign rsp.kind = okind_ff; assign rsp.outcome = oout_ff;
   assign rsp.page = opage_ff; assign rsp.frame = oframe_ff; assign rsp.dirty = odirty_ff;
   assign rsp.last = okind_ff;

   logic unused;
   assign unused = ^{gmn, gdn, gpage[0], ff_any};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.page)) else $error("stall lost");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff + mcnt_ff <= CB'(MaxPages)) else $error("frames overflow");
endmodule
